// ----- rtl/core/wbps_pkg.sv -----
// package: widths, request kinds and register indexes for the pattern search
`timescale 1ns / 1ps
package wbps_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int ADDR_WIDTH  = 64;

  localparam int IDX_W     = $clog2(PATTERN_MAX);
  localparam int SEEN_W    = $clog2(PATTERN_MAX + 1);
  localparam int LEN_W     = 6;
  localparam int BYTE_W    = 8;
  localparam int PIDX_W    = 5;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;

  // request payload: pattern_index, byte_value, region_base, padded to bytes
  localparam int IN_RAW_W  = PIDX_W + BYTE_W + ADDR_WIDTH;
  localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ADDR_WIDTH + 7) / 8) * 8;

  localparam int BYTE_LSB = PIDX_W;
  localparam int BASE_LSB = PIDX_W + BYTE_W;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_REGION = 2'd1,
    OP_BYTE   = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_WILDCARD_VALUE = 2'd1,
    REG_MIN_ADDRESS    = 2'd2,
    REG_MAX_ADDRESS    = 2'd3
  } cfg_reg_t;

endpackage

// ----- rtl/core/wildcard_byte_pattern_search.sv -----
// top level: wildcard byte pattern search over streamed memory regions
`timescale 1ns / 1ps
// Takes one request per clock. Load requests write pattern bytes, a region
// request sets the base address, and each memory byte request shifts into a
// window that is compared with the pattern, a wildcard pattern byte matching
// anything. A match whose start address lies in [min_address, max_address)
// goes from the window compare register through the result register to the
// output. The input stalls only when a match sits in the compare register
// while the result register is still held by the downstream side.
module wildcard_byte_pattern_search (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wbps_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // pattern_index, byte_value, region_base, zero pad
  input  logic [wbps_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // op
  input  logic [wbps_pkg::OP_W-1:0]          s_axis_tuser,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // match_address
  output logic [wbps_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import wbps_pkg::*;

  localparam int WIN_W = PATTERN_MAX * BYTE_W;

  // configuration
  logic [LEN_W-1:0]      pattern_length;
  logic [BYTE_W-1:0]     wildcard_value;
  logic [ADDR_WIDTH-1:0] min_address;
  logic [ADDR_WIDTH-1:0] max_address;

  // state
  logic [BYTE_W-1:0]     pattern_store [PATTERN_MAX];
  logic [BYTE_W-1:0]     byte_window [PATTERN_MAX];
  logic [SEEN_W-1:0]     bytes_seen;
  logic [ADDR_WIDTH-1:0] next_address;

  // compare stage
  logic                  s1_valid;
  logic                  s1_gate;
  logic [PATTERN_MAX-1:0] s1_lane_ok;
  logic [ADDR_WIDTH-1:0] s1_start;

  // request fields
  op_t                   in_op;
  logic [PIDX_W-1:0]     in_index;
  logic [BYTE_W-1:0]     in_byte;
  logic [ADDR_WIDTH-1:0] in_base;
  logic                  in_accept;

  logic [LEN_W-1:0]      n_used;
  logic [LEN_W-1:0]      n_minus1;
  logic [IDX_W-1:0]      nm1;
  logic [IDX_W-1:0]      shamt;
  logic [BYTE_W-1:0]     win_new [PATTERN_MAX];
  logic [WIN_W-1:0]      win_rev;
  logic [WIN_W-1:0]      win_aligned;
  logic [PATTERN_MAX-1:0] lane_ok;
  logic [SEEN_W-1:0]     seen_inc;
  logic                  gate_next;
  logic [ADDR_WIDTH-1:0] start_next;

  logic                  s1_hit;
  logic                  out_free;
  logic                  s1_adv;

  assign in_op     = op_t'(s_axis_tuser);
  assign in_index  = s_axis_tdata[PIDX_W-1:0];
  assign in_byte   = s_axis_tdata[BYTE_LSB +: BYTE_W];
  assign in_base   = s_axis_tdata[BASE_LSB +: ADDR_WIDTH];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // clamp the pattern length to 1..PATTERN_MAX
  always_comb begin
    if (pattern_length == '0) begin
      n_used = LEN_W'(1);
    end else if (pattern_length > LEN_W'(PATTERN_MAX)) begin
      n_used = LEN_W'(PATTERN_MAX);
    end else begin
      n_used = pattern_length;
    end
    n_minus1 = n_used - LEN_W'(1);
    nm1      = n_minus1[IDX_W-1:0];
    shamt    = IDX_W'(PATTERN_MAX - 1) - nm1;
  end

  // window after the new byte, reversed and shifted so lane j sees byte n-1-j
  always_comb begin
    win_new[0] = in_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_new[k] = byte_window[k-1];
    end
    for (int i = 0; i < PATTERN_MAX; i++) begin
      win_rev[i*BYTE_W +: BYTE_W] = win_new[PATTERN_MAX-1-i];
    end
    win_aligned = win_rev >> {shamt, 3'b000};
    for (int j = 0; j < PATTERN_MAX; j++) begin
      lane_ok[j] = (IDX_W'(j) > nm1) || (pattern_store[j] == wildcard_value) ||
                   (pattern_store[j] == win_aligned[j*BYTE_W +: BYTE_W]);
    end
  end

  always_comb begin
    if (bytes_seen < SEEN_W'(PATTERN_MAX)) begin
      seen_inc = bytes_seen + SEEN_W'(1);
    end else begin
      seen_inc = bytes_seen;
    end
    gate_next  = (seen_inc >= SEEN_W'(n_used));
    start_next = next_address - {{(ADDR_WIDTH-IDX_W){1'b0}}, nm1};
  end

  // handshake
  assign s1_hit   = s1_valid && s1_gate && (&s1_lane_ok) &&
                    (s1_start >= min_address) && (s1_start < max_address);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s1_adv   = !s1_hit || out_free;
  assign s_axis_tready = !s1_valid || s1_adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_W'(1);
      wildcard_value <= BYTE_W'(17);
      min_address    <= '0;
      max_address    <= '1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        REG_WILDCARD_VALUE: wildcard_value <= cfg_data[BYTE_W-1:0];
        REG_MIN_ADDRESS:    min_address    <= cfg_data[ADDR_WIDTH-1:0];
        REG_MAX_ADDRESS:    max_address    <= cfg_data[ADDR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // pattern storage
  always_ff @(posedge clk) begin
    if (in_accept && in_op == OP_LOAD && 32'(in_index) < PATTERN_MAX) begin
      pattern_store[in_index[IDX_W-1:0]] <= in_byte;
    end
  end

  // window storage, entry 0 newest
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        byte_window[k] <= '0;
      end
    end else if (in_accept && in_op == OP_BYTE) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        byte_window[k] <= win_new[k];
      end
    end
  end

  // region tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen   <= '0;
      next_address <= '0;
    end else if (in_accept) begin
      unique case (in_op)
        OP_REGION: begin
          next_address <= in_base;
          bytes_seen   <= '0;
        end
        OP_BYTE: begin
          next_address <= next_address + ADDR_WIDTH'(1);
          bytes_seen   <= s_axis_tlast ? '0 : seen_inc;
        end
        default: ;
      endcase
    end
  end

  // compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= in_accept && (in_op == OP_BYTE);
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      s1_gate    <= gate_next;
      s1_lane_ok <= lane_ok;
      s1_start   <= start_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_hit && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_hit && out_free) begin
      m_axis_tdata <= OUT_DATA_W'(s1_start);
    end
  end

`ifndef NO_ASSERTIONS
  a_result_in_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[ADDR_WIDTH-1:0] >= min_address) &&
                      (m_axis_tdata[ADDR_WIDTH-1:0] < max_address))
    else $error("result address outside the reporting range");

  a_seen_bounded: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= SEEN_W'(PATTERN_MAX))
    else $error("byte count beyond pattern capacity");

  a_region_start: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_op == OP_REGION) |=>
      (next_address == $past(in_base)) && (bytes_seen == '0))
    else $error("region request did not set base and clear count");

  a_byte_enters_compare: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_op == OP_BYTE) |=> s1_valid)
    else $error("accepted memory byte missing from compare stage");

  a_hit_not_dropped: assert property (@(posedge clk) disable iff (rst)
    (s1_hit && !out_free) |=> s1_valid && $stable(s1_start))
    else $error("pending match lost from compare stage");
`endif

endmodule

// ----- bench/wildcard_byte_pattern_search_tb.sv -----
// testbench: wildcard byte pattern search, random streams checked against a predictor
`timescale 1ns / 1ps
module wildcard_byte_pattern_search_tb;
  import wbps_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int LIMIT_CYCLES = 800000;
  localparam int RANDOM_REQS = 1800;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam logic [ADDR_WIDTH-1:0] ADDR_TOP = '1;

  typedef struct {
    logic [OP_W-1:0]       op;
    logic [PIDX_W-1:0]     idx;
    logic [BYTE_W-1:0]     val;
    logic [ADDR_WIDTH-1:0] base;
    logic                  is_last;
  } req_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  wildcard_byte_pattern_search dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  req_t                  pending_reqs[$];
  logic [ADDR_WIDTH-1:0] expected_matches[$];
  req_t                  cur_req;
  logic [IN_DATA_W-1:0]  packed_req;
  logic                  req_taken = 1'b0;
  bit                    calm = 1'b0;
  int unsigned           reqs_queued = 0;
  int unsigned           reqs_taken = 0;
  int unsigned           reqs_counted = 0;
  int unsigned           errors = 0;
  int unsigned           matches_checked = 0;
  int unsigned           n_bytes = 0;
  int unsigned           n_regions = 0;
  int unsigned           n_loads = 0;
  int unsigned           n_settings = 0;
  int unsigned           longest_len = 1;

  // predictor copy of the block
  logic [LEN_W-1:0]      len_reg;
  logic [BYTE_W-1:0]     wild_reg;
  logic [ADDR_WIDTH-1:0] lo_reg;
  logic [ADDR_WIDTH-1:0] hi_reg;
  logic [BYTE_W-1:0]     pat_mirror [PATTERN_MAX];
  logic [BYTE_W-1:0]     win_mirror [PATTERN_MAX];
  int unsigned           seen_cnt;
  logic [ADDR_WIDTH-1:0] next_addr;
  logic [ADDR_WIDTH-1:0] want_addr;

  // stimulus-side view of the pattern, used to plant matches
  logic [BYTE_W-1:0]     plan_pat [PATTERN_MAX];
  logic [BYTE_W-1:0]     plan_wild = 8'd17;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic predict_match(input req_t r);
    int unsigned n;
    logic [ADDR_WIDTH-1:0] addr;
    logic [ADDR_WIDTH-1:0] start;
    bit hit;
    case (r.op)
      OP_LOAD: pat_mirror[r.idx] = r.val;
      OP_REGION: begin
        next_addr = r.base;
        seen_cnt = 0;
      end
      OP_BYTE: begin
        n = (len_reg == 0) ? 1 : (len_reg > PATTERN_MAX) ? PATTERN_MAX : len_reg;
        addr = next_addr;
        for (int k = PATTERN_MAX - 1; k > 0; k--) win_mirror[k] = win_mirror[k - 1];
        win_mirror[0] = r.val;
        if (seen_cnt < PATTERN_MAX) seen_cnt++;
        next_addr = addr + ADDR_WIDTH'(1);
        if (seen_cnt >= n) begin
          hit = 1'b1;
          for (int j = 0; j < n; j++)
            if (pat_mirror[j] != wild_reg && pat_mirror[j] != win_mirror[n - 1 - j]) hit = 1'b0;
          start = addr - ADDR_WIDTH'(n - 1);
          if (hit && start >= lo_reg && start < hi_reg)
            expected_matches = {expected_matches, start};
        end
        if (r.is_last) seen_cnt = 0;
      end
      default: ;
    endcase
  endtask

  // driver: requests from the pending queue, result-side backpressure
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_taken) begin
      if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
        cur_req = pending_reqs.pop_front();
        packed_req = '0;
        packed_req[PIDX_W-1:0] = cur_req.idx;
        packed_req[BYTE_LSB +: BYTE_W] = cur_req.val;
        packed_req[BASE_LSB +: ADDR_WIDTH] = cur_req.base;
        s_axis_tdata <= packed_req;
        s_axis_tuser <= cur_req.op;
        s_axis_tlast <= cur_req.is_last;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 20);
  end

  // monitor: register writes, accepted requests, accepted results
  always @(posedge clk) begin
    if (rst) begin
      len_reg = LEN_W'(1);
      wild_reg = 8'd17;
      lo_reg = '0;
      hi_reg = ADDR_TOP;
      for (int k = 0; k < PATTERN_MAX; k++) begin
        pat_mirror[k] = '0;
        win_mirror[k] = '0;
      end
      seen_cnt = 0;
      next_addr = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_LENGTH: len_reg = cfg_data[LEN_W-1:0];
          REG_WILDCARD_VALUE: wild_reg = cfg_data[BYTE_W-1:0];
          REG_MIN_ADDRESS:    lo_reg = cfg_data[ADDR_WIDTH-1:0];
          REG_MAX_ADDRESS:    hi_reg = cfg_data[ADDR_WIDTH-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_match(cur_req);
        reqs_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_matches.size() == 0) begin
          report_mismatch($sformatf("unexpected match_address %h", m_axis_tdata));
        end else begin
          want_addr = expected_matches.pop_front();
          matches_checked++;
          if (m_axis_tdata[ADDR_WIDTH-1:0] != want_addr)
            report_mismatch($sformatf("match_address %h, want %h",
                                      m_axis_tdata[ADDR_WIDTH-1:0], want_addr));
        end
      end
    end
    req_taken <= !rst && s_axis_tvalid && s_axis_tready;
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [BYTE_W-1:0] pick_pat_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return plan_wild;
      3, 4, 5: return 8'hA5;
      6, 7, 8: return 8'h5A;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_req(input logic [OP_W-1:0] op, input logic [PIDX_W-1:0] idx,
                           input logic [BYTE_W-1:0] val, input logic [ADDR_WIDTH-1:0] base,
                           input logic is_last);
    req_t r;
    r.op = op;
    r.idx = idx;
    r.val = val;
    r.base = base;
    r.is_last = is_last;
    pending_reqs = {pending_reqs, r};
    reqs_queued++;
    if (op != OP_SPARE) reqs_counted++;
  endtask

  task automatic load_pat(input int unsigned idx, input logic [BYTE_W-1:0] val);
    plan_pat[idx] = val;
    n_loads++;
    queue_req(OP_LOAD, PIDX_W'(idx), val, rnd64(), 1'($urandom));
  endtask

  task automatic open_region(input logic [ADDR_WIDTH-1:0] base);
    n_regions++;
    queue_req(OP_REGION, PIDX_W'($urandom), 8'($urandom), base, 1'($urandom));
  endtask

  task automatic mem_byte(input logic [BYTE_W-1:0] val, input logic is_last);
    n_bytes++;
    queue_req(OP_BYTE, PIDX_W'($urandom), val, rnd64(), is_last);
  endtask

  task automatic spare_req();
    queue_req(OP_SPARE, PIDX_W'($urandom), 8'($urandom), rnd64(), 1'($urandom));
  endtask

  task automatic set_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
  endtask

  task automatic set_config(input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] wild,
                            input logic [ADDR_WIDTH-1:0] lo, input logic [ADDR_WIDTH-1:0] hi);
    plan_wild = wild;
    n_settings++;
    set_reg(REG_PATTERN_LENGTH, CFG_W'(len));
    set_reg(REG_WILDCARD_VALUE, CFG_W'(wild));
    set_reg(REG_MIN_ADDRESS, CFG_W'(lo));
    set_reg(REG_MAX_ADDRESS, CFG_W'(hi));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every request is in and every match is out, then let the pipe settle
  task automatic drain();
    int unsigned waited;
    waited = 0;
    while (reqs_taken != reqs_queued) @(negedge clk);
    while (expected_matches.size() != 0 && waited < 400) begin
      @(negedge clk);
      waited++;
    end
    if (expected_matches.size() != 0) begin
      report_mismatch($sformatf("%0d expected matches never came out",
                                expected_matches.size()));
      expected_matches.delete();
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic gen_region(input int unsigned n, input logic [ADDR_WIDTH-1:0] base,
                            input bit with_start);
    logic [BYTE_W-1:0] bytes_buf [80];
    int unsigned len;
    int unsigned off;
    bit end_mark;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 72) : $urandom_range(1, 40);
    for (int i = 0; i < len; i++)
      bytes_buf[i] = ($urandom_range(0, 4) == 0) ? 8'($urandom) :
                     ($urandom_range(0, 1) ? 8'hA5 : 8'h5A);
    if (n <= len && $urandom_range(0, 9) < 6) begin
      off = $urandom_range(0, len - n);
      for (int j = 0; j < n; j++)
        if (plan_pat[j] != plan_wild) bytes_buf[off + j] = plan_pat[j];
    end
    end_mark = ($urandom_range(0, 9) != 0);
    if (with_start) open_region(base);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 39))
        0: spare_req();
        1: load_pat($urandom_range(0, PATTERN_MAX - 1), pick_pat_byte());
        default: ;
      endcase
      mem_byte(bytes_buf[i], end_mark && (i == len - 1));
    end
  endtask

  initial begin
    int unsigned directed_reqs;
    int unsigned n;
    int unsigned regions;
    logic [LEN_W-1:0] plan_len;
    logic [BYTE_W-1:0] wild;
    logic [ADDR_WIDTH-1:0] phase_base;
    logic [ADDR_WIDTH-1:0] lo;
    logic [ADDR_WIDTH-1:0] hi;
    logic [ADDR_WIDTH-1:0] base;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: one-byte pattern, wildcard 17, every address but the top one
    load_pat(0, 8'hAB);
    mem_byte(8'hAB, 1'b0);
    mem_byte(8'h00, 1'b0);
    mem_byte(8'hAB, 1'b1);
    mem_byte(8'hAB, 1'b0);
    spare_req();
    open_region(ADDR_TOP - ADDR_WIDTH'(1));
    mem_byte(8'hAB, 1'b0);
    mem_byte(8'hAB, 1'b0);
    mem_byte(8'hAB, 1'b1);
    load_pat(PATTERN_MAX - 1, 8'hFF);
    load_pat(0, 8'd17);
    mem_byte(8'h00, 1'b0);
    mem_byte(8'hFF, 1'b1);
    drain();

    // zero length acts as one, narrow address window
    set_config('0, 8'hFF, 64'd5, 64'd8);
    load_pat(0, 8'hFF);
    open_region('0);
    for (int i = 0; i < 10; i++) mem_byte(8'($urandom), i == 9);
    drain();
    directed_reqs = reqs_counted;

    while (reqs_counted < directed_reqs + RANDOM_REQS) begin
      calm = (reqs_counted >= directed_reqs + 700) && (reqs_counted < directed_reqs + 1000);
      case ($urandom_range(0, 9))
        0: plan_len = 0;
        1: plan_len = 1;
        2, 3, 4, 5: plan_len = LEN_W'($urandom_range(2, 6));
        6: plan_len = LEN_W'($urandom_range(7, 16));
        7: plan_len = LEN_W'(PATTERN_MAX);
        8: plan_len = LEN_W'($urandom_range(PATTERN_MAX + 1, 63));
        default: plan_len = LEN_W'($urandom_range(17, PATTERN_MAX - 1));
      endcase
      n = (plan_len == 0) ? 1 : (plan_len > PATTERN_MAX) ? PATTERN_MAX : plan_len;
      if (n > longest_len) longest_len = n;
      case ($urandom_range(0, 5))
        0: wild = 8'h00;
        1: wild = 8'hFF;
        default: wild = 8'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: phase_base = '0;
        1: phase_base = ADDR_TOP - ADDR_WIDTH'($urandom_range(0, 40));
        default: phase_base = rnd64();
      endcase
      case ($urandom_range(0, 7))
        4: begin
          lo = phase_base + ADDR_WIDTH'($urandom_range(0, 20));
          hi = lo + ADDR_WIDTH'($urandom_range(0, 40));
        end
        5: begin
          lo = ADDR_TOP;
          hi = ADDR_TOP;
        end
        6: begin
          lo = '0;
          hi = '0;
        end
        7: begin
          lo = phase_base;
          hi = ADDR_TOP;
        end
        default: begin
          lo = '0;
          hi = ADDR_TOP;
        end
      endcase
      set_config(plan_len, wild, lo, hi);
      for (int j = 0; j < n; j++) load_pat(j, pick_pat_byte());
      regions = $urandom_range(2, 6);
      for (int r = 0; r < regions; r++) begin
        case ($urandom_range(0, 9))
          0: base = rnd64();
          1: base = ADDR_TOP - ADDR_WIDTH'($urandom_range(0, 50));
          default: base = phase_base + ADDR_WIDTH'($urandom_range(0, 60));
        endcase
        gen_region(n, base, $urandom_range(0, 7) != 0);
      end
      drain();
    end
    calm = 1'b0;

    $display("sent %0d requests: %0d memory bytes, %0d region starts, %0d pattern loads",
             reqs_counted, n_bytes, n_regions, n_loads);
    $display("checked %0d matches over %0d register settings, patterns up to %0d bytes",
             matches_checked, n_settings, longest_len);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("timeout: run did not finish");
    $display("== FAIL ==");
    $finish;
  end

endmodule
